@@ src/i2c_register_access_master_top_defines.svh @@
// Assertion macros used by the sequencer RTL of the I2C register access master.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef I2C_REGISTER_ACCESS_MASTER_TOP_DEFINES_SVH
`define I2C_REGISTER_ACCESS_MASTER_TOP_DEFINES_SVH

`ifndef SYNTHESIS

`define I2C_RAM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define I2C_RAM_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define I2C_RAM_ASSERT(label, prop, msg)

`define I2C_RAM_ASSERT_NEVER(label, cond, msg)

`endif

`endif

@@ src/i2c_ram_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package i2c_ram_pkg;

    localparam logic [1:0]  KIND_TICK  = 2'd0;
    localparam logic [1:0]  KIND_WRITE = 2'd1;
    localparam logic [1:0]  KIND_READ  = 2'd2;

    localparam logic [15:0] ACK_RETRY_RESET = 16'd1000;

    typedef struct packed {
        logic [1:0] kind;
        logic       sda_in;
        logic [6:0] device_addr;
        logic [7:0] reg_addr;
        logic [7:0] write_data;
        logic [7:0] read_count;
    } req_t;

    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       busy_res;
        logic [7:0] read_byte;
        logic       byte_valid;
        logic       last_byte;
        logic       ack_missing;
        logic       done_res;
    } res_t;

endpackage

`default_nettype wire

@@ src/i2c_ram_in_stage.sv @@
`timescale 1ns / 1ps
`default_nettype none

module i2c_ram_in_stage
    import i2c_ram_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_ready,
    input  wire req_t in_req,
    output logic      req_valid,
    output req_t      req,
    input  wire logic req_take
);

    logic valid_reg;
    logic valid_next;
    req_t req_reg;

    assign in_ready  = !valid_reg || req_take;
    assign req_valid = valid_reg;
    assign req       = req_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_ready)
        begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            req_reg <= in_req;
        end
    end

endmodule

`default_nettype wire

@@ src/i2c_ram_seq.sv @@
`timescale 1ns / 1ps
`default_nettype none

module i2c_ram_seq
    import i2c_ram_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [15:0] cfg_data,
    input  wire logic        step_en,
    input  wire req_t        req,
    output res_t             res
);

    `include "i2c_register_access_master_top_defines.svh"

    typedef enum logic [3:0] {
        P_IDLE     = 4'd0,
        P_START    = 4'd1,
        P_DEVW     = 4'd2,
        P_ACK_DEVW = 4'd3,
        P_REG      = 4'd4,
        P_ACK_REG  = 4'd5,
        P_DATA     = 4'd6,
        P_ACK_DATA = 4'd7,
        P_RESTART  = 4'd8,
        P_DEVR     = 4'd9,
        P_ACK_DEVR = 4'd10,
        P_READ     = 4'd11,
        P_MACK     = 4'd12,
        P_STOP     = 4'd13
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [1:0]  sub_reg, sub_next;
    logic [3:0]  bit_index_reg, bit_index_next;
    logic [7:0]  shift_reg, shift_next;
    logic [7:0]  bytes_left_reg, bytes_left_next;
    logic [15:0] retry_left_reg, retry_left_next;
    logic [6:0]  saved_device_reg, saved_device_next;
    logic [7:0]  saved_register_reg, saved_register_next;
    logic [7:0]  saved_data_reg, saved_data_next;
    logic        ack_error_reg, ack_error_next;
    logic        read_mode_reg, read_mode_next;
    logic [15:0] limit_reg;

    logic        out_bit;
    logic [15:0] retry_dec;
    logic [3:0]  bit_index_inc;
    logic        ack_end;

    assign out_bit       = shift_reg[7];
    assign retry_dec     = retry_left_reg - 16'd1;
    assign bit_index_inc = bit_index_reg + 4'd1;

    always_comb
    begin
        phase_next          = phase_reg;
        sub_next            = sub_reg;
        bit_index_next      = bit_index_reg;
        shift_next          = shift_reg;
        bytes_left_next     = bytes_left_reg;
        retry_left_next     = retry_left_reg;
        saved_device_next   = saved_device_reg;
        saved_register_next = saved_register_reg;
        saved_data_next     = saved_data_reg;
        ack_error_next      = ack_error_reg;
        read_mode_next      = read_mode_reg;
        ack_end             = 1'b0;

        res            = '0;
        res.scl_level  = 1'b1;
        res.sda_level  = 1'b1;

        unique case (phase_reg)
            P_START, P_RESTART:
            begin
                if (sub_reg == 2'd0)
                begin
                    sub_next = 2'd1;
                end
                else if (sub_reg == 2'd1)
                begin
                    res.sda_level = 1'b0;
                    sub_next      = 2'd2;
                end
                else
                begin
                    res.scl_level  = 1'b0;
                    res.sda_level  = 1'b0;
                    bit_index_next = 4'd0;
                    sub_next       = 2'd0;
                    if (phase_reg == P_START)
                    begin
                        phase_next = P_DEVW;
                        shift_next = {saved_device_reg, 1'b0};
                    end
                    else
                    begin
                        phase_next = P_DEVR;
                        shift_next = {saved_device_reg, 1'b1};
                    end
                end
            end

            P_DEVW, P_REG, P_DATA, P_DEVR:
            begin
                if (sub_reg == 2'd0)
                begin
                    res.scl_level = 1'b0;
                    res.sda_level = out_bit;
                    sub_next      = 2'd1;
                end
                else if (sub_reg == 2'd1)
                begin
                    res.sda_level = out_bit;
                    sub_next      = 2'd2;
                end
                else
                begin
                    res.scl_level = 1'b0;
                    shift_next    = {shift_reg[6:0], 1'b0};
                    sub_next      = 2'd0;
                    if (bit_index_reg >= 4'd7)
                    begin
                        res.sda_level   = 1'b1;
                        retry_left_next = (limit_reg == 16'd0) ? 16'd1 : limit_reg;
                        unique case (phase_reg)
                            P_DEVW:  phase_next = P_ACK_DEVW;
                            P_REG:   phase_next = P_ACK_REG;
                            P_DATA:  phase_next = P_ACK_DATA;
                            default: phase_next = P_ACK_DEVR;
                        endcase
                    end
                    else
                    begin
                        res.sda_level  = out_bit;
                        bit_index_next = bit_index_inc;
                    end
                end
            end

            P_ACK_DEVW, P_ACK_REG, P_ACK_DATA, P_ACK_DEVR:
            begin
                if (sub_reg == 2'd0)
                begin
                    res.scl_level = 1'b0;
                    sub_next      = 2'd1;
                end
                else if (sub_reg == 2'd1)
                begin
                    sub_next = 2'd2;
                end
                else
                begin
                    res.scl_level = 1'b0;
                    sub_next      = 2'd0;
                    if (!req.sda_in)
                    begin
                        ack_end = 1'b1;
                    end
                    else
                    begin
                        retry_left_next = retry_dec;
                        if (retry_dec == 16'd0)
                        begin
                            ack_error_next = 1'b1;
                            ack_end        = 1'b1;
                        end
                    end
                end

                if (ack_end)
                begin
                    unique case (phase_reg)
                        P_ACK_DEVW:
                        begin
                            phase_next     = P_REG;
                            shift_next     = saved_register_reg;
                            bit_index_next = 4'd0;
                        end
                        P_ACK_REG:
                        begin
                            if (read_mode_reg)
                            begin
                                phase_next = P_RESTART;
                            end
                            else
                            begin
                                phase_next     = P_DATA;
                                shift_next     = saved_data_reg;
                                bit_index_next = 4'd0;
                            end
                        end
                        P_ACK_DEVR:
                        begin
                            if (bytes_left_reg == 8'd0)
                            begin
                                phase_next = P_STOP;
                            end
                            else
                            begin
                                phase_next     = P_READ;
                                shift_next     = 8'd0;
                                bit_index_next = 4'd0;
                            end
                        end
                        default:
                        begin
                            phase_next = P_STOP;
                        end
                    endcase
                end
            end

            P_READ:
            begin
                if (sub_reg == 2'd0)
                begin
                    sub_next = 2'd1;
                end
                else
                begin
                    res.scl_level  = 1'b0;
                    shift_next     = {shift_reg[6:0], req.sda_in};
                    bit_index_next = bit_index_inc;
                    sub_next       = 2'd0;
                    if (bit_index_inc >= 4'd8)
                    begin
                        res.byte_valid  = 1'b1;
                        res.read_byte   = {shift_reg[6:0], req.sda_in};
                        res.last_byte   = (bytes_left_reg == 8'd1);
                        bytes_left_next = bytes_left_reg - 8'd1;
                        phase_next      = P_MACK;
                    end
                end
            end

            P_MACK:
            begin
                res.sda_level = (bytes_left_reg == 8'd0);
                if (sub_reg == 2'd0)
                begin
                    res.scl_level = 1'b0;
                    sub_next      = 2'd1;
                end
                else if (sub_reg == 2'd1)
                begin
                    sub_next = 2'd2;
                end
                else
                begin
                    res.scl_level = 1'b0;
                    sub_next      = 2'd0;
                    if (bytes_left_reg == 8'd0)
                    begin
                        phase_next = P_STOP;
                    end
                    else
                    begin
                        phase_next     = P_READ;
                        shift_next     = 8'd0;
                        bit_index_next = 4'd0;
                    end
                end
            end

            P_STOP:
            begin
                if (sub_reg == 2'd0)
                begin
                    res.sda_level = 1'b0;
                    sub_next      = 2'd1;
                end
                else
                begin
                    res.done_res = 1'b1;
                    phase_next   = P_IDLE;
                    sub_next     = 2'd0;
                end
            end

            default:
            begin
                phase_next = P_IDLE;
                sub_next   = 2'd0;
                if (req.kind == KIND_WRITE || req.kind == KIND_READ)
                begin
                    saved_device_next   = req.device_addr;
                    saved_register_next = req.reg_addr;
                    saved_data_next     = req.write_data;
                    bytes_left_next     = req.read_count;
                    read_mode_next      = (req.kind == KIND_READ);
                    ack_error_next      = 1'b0;
                    phase_next          = P_START;
                    sub_next            = 2'd1;
                end
            end
        endcase

        res.busy_res    = (phase_next != P_IDLE);
        res.ack_missing = ack_error_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg          <= ACK_RETRY_RESET;
            phase_reg          <= P_IDLE;
            sub_reg            <= 2'd0;
            bit_index_reg      <= 4'd0;
            shift_reg          <= 8'd0;
            bytes_left_reg     <= 8'd0;
            retry_left_reg     <= 16'd0;
            saved_device_reg   <= 7'd0;
            saved_register_reg <= 8'd0;
            saved_data_reg     <= 8'd0;
            ack_error_reg      <= 1'b0;
            read_mode_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                limit_reg <= cfg_data;
            end
            if (step_en)
            begin
                phase_reg          <= phase_next;
                sub_reg            <= sub_next;
                bit_index_reg      <= bit_index_next;
                shift_reg          <= shift_next;
                bytes_left_reg     <= bytes_left_next;
                retry_left_reg     <= retry_left_next;
                saved_device_reg   <= saved_device_next;
                saved_register_reg <= saved_register_next;
                saved_data_reg     <= saved_data_next;
                ack_error_reg      <= ack_error_next;
                read_mode_reg      <= read_mode_next;
            end
        end
    end

    `I2C_RAM_ASSERT(a_byte_then_mack, step_en && res.byte_valid |=> phase_reg == P_MACK, "received byte not followed by master acknowledge")
    `I2C_RAM_ASSERT(a_done_then_idle, step_en && res.done_res |=> phase_reg == P_IDLE, "stop completed but sequencer not idle")
    `I2C_RAM_ASSERT_NEVER(a_last_needs_valid, res.last_byte && !res.byte_valid, "last byte flagged without a received byte")
    `I2C_RAM_ASSERT_NEVER(a_read_bit_range, phase_reg == P_READ && bit_index_reg > 4'd7, "read bit counter out of range")

endmodule

`default_nettype wire

@@ src/i2c_ram_out_stage.sv @@
`timescale 1ns / 1ps
`default_nettype none

module i2c_ram_out_stage
    import i2c_ram_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic res_valid,
    output logic      res_ready,
    input  wire res_t res_in,
    output logic      out_valid,
    input  wire logic out_ready,
    output res_t      res_out
);

    logic valid_reg;
    logic valid_next;
    res_t res_reg;

    assign res_ready = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign res_out   = res_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (res_ready)
        begin
            valid_next = res_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            res_reg <= res_in;
        end
    end

endmodule

`default_nettype wire

@@ src/i2c_register_access_master_top.sv @@
// I2C register access master, one request per step of the bus sequence.
// Input channel (in_valid/in_ready): each request carries kind (tick, start write,
// start read), the sampled SDA level and the transaction fields. Requests that start
// a transaction while one is running are treated as plain ticks.
// Output channel (out_valid/out_ready): exactly one result per request, giving the
// SCL and SDA levels to drive, busy, received bytes, missing-acknowledge and done flags.
// Configuration: cfg_we with cfg_data writes the acknowledge retry limit; write it
// only while no request is in flight.
// The input register captures each accepted request, and the sequencer step computed
// from it is loaded into the result register once that register can take it.
// Throughput is one request per cycle while the receiver does not stall.
// When the receiver stalls, the result register holds and the input register fills;
// in_ready drops only when both are occupied.
// Reset clears the sequencer to idle with the lines released, empties both registers
// and sets the retry limit to 1000.
`timescale 1ns / 1ps
`default_nettype none

module i2c_register_access_master_top
    import i2c_ram_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [15:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  kind,
    input  wire logic        sda_in,
    input  wire logic [6:0]  device_addr,
    input  wire logic [7:0]  reg_addr,
    input  wire logic [7:0]  write_data,
    input  wire logic [7:0]  read_count,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             scl_level,
    output logic             sda_level,
    output logic             busy_res,
    output logic [7:0]       read_byte,
    output logic             byte_valid,
    output logic             last_byte,
    output logic             ack_missing,
    output logic             done_res
);

    req_t in_req;
    req_t req;
    logic req_valid;
    logic res_ready;
    logic step_en;
    res_t res;
    res_t res_out;

    assign in_req.kind        = kind;
    assign in_req.sda_in      = sda_in;
    assign in_req.device_addr = device_addr;
    assign in_req.reg_addr    = reg_addr;
    assign in_req.write_data  = write_data;
    assign in_req.read_count  = read_count;

    assign step_en = req_valid && res_ready;

    i2c_ram_in_stage u_in_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_req    (in_req),
        .req_valid (req_valid),
        .req       (req),
        .req_take  (res_ready)
    );

    i2c_ram_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .step_en  (step_en),
        .req      (req),
        .res      (res)
    );

    i2c_ram_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (req_valid),
        .res_ready (res_ready),
        .res_in    (res),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .res_out   (res_out)
    );

    assign scl_level   = res_out.scl_level;
    assign sda_level   = res_out.sda_level;
    assign busy_res    = res_out.busy_res;
    assign read_byte   = res_out.read_byte;
    assign byte_valid  = res_out.byte_valid;
    assign last_byte   = res_out.last_byte;
    assign ack_missing = res_out.ack_missing;
    assign done_res    = res_out.done_res;

endmodule

`default_nettype wire

@@ bench/tb_i2c_register_access_master_top.sv @@
`timescale 1ns / 1ps

module tb_i2c_register_access_master_top;
    import i2c_ram_pkg::*;

    localparam int         HALF_PERIOD      = 5;
    localparam int         WATCHDOG_LIMIT   = 1000;
    localparam int         LONG_HOLD_CYCLES = 60;
    localparam logic [1:0] KIND_UNUSED      = 2'd3;

    typedef enum logic [4:0] {
        PH_IDLE     = 5'd0,
        PH_START    = 5'd1,
        PH_DEVW     = 5'd2,
        PH_ACK_DEVW = 5'd3,
        PH_REG      = 5'd4,
        PH_ACK_REG  = 5'd5,
        PH_DATA     = 5'd6,
        PH_ACK_DATA = 5'd7,
        PH_RESTART  = 5'd8,
        PH_DEVR     = 5'd9,
        PH_ACK_DEVR = 5'd10,
        PH_READ     = 5'd11,
        PH_MACK     = 5'd12,
        PH_STOP     = 5'd13
    } bus_phase_t;

    typedef struct {
        bus_phase_t  phase;
        logic [1:0]  sub;
        logic [3:0]  bit_index;
        logic [7:0]  shift_byte;
        logic [7:0]  bytes_left;
        logic [15:0] retry_left;
        logic [6:0]  dev_addr;
        logic [7:0]  reg_byte;
        logic [7:0]  data_byte;
        logic        ack_error;
        logic        read_mode;
    } bus_state_t;

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        cfg_we      = 1'b0;
    logic [15:0] cfg_data    = 16'd0;
    logic        in_valid    = 1'b0;
    logic        in_ready;
    logic [1:0]  kind        = KIND_TICK;
    logic        sda_in      = 1'b0;
    logic [6:0]  device_addr = 7'd0;
    logic [7:0]  reg_addr    = 8'd0;
    logic [7:0]  write_data  = 8'd0;
    logic [7:0]  read_count  = 8'd0;
    logic        out_valid;
    logic        out_ready   = 1'b0;
    logic        scl_level;
    logic        sda_level;
    logic        busy_res;
    logic [7:0]  read_byte;
    logic        byte_valid;
    logic        last_byte;
    logic        ack_missing;
    logic        done_res;

    req_t        pending_requests[$];
    res_t        expected_levels[$];
    bus_state_t  model_bus;
    bus_state_t  plan_bus;
    logic [15:0] model_limit;
    logic [15:0] plan_limit;

    int          planned_items       = 0;
    int          accepted_requests   = 0;
    int          steps_checked       = 0;
    int          bytes_received      = 0;
    int          transactions_done   = 0;
    int          nacked_transactions = 0;
    int          error_count         = 0;
    int          burst_left          = 0;
    int          gap_left            = 0;
    int          hold_left           = 0;
    int          stall_mode          = 0;
    int          stall_timer         = 0;
    logic        long_hold_request   = 1'b0;

    i2c_register_access_master_top u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .kind        (kind),
        .sda_in      (sda_in),
        .device_addr (device_addr),
        .reg_addr    (reg_addr),
        .write_data  (write_data),
        .read_count  (read_count),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .scl_level   (scl_level),
        .sda_level   (sda_level),
        .busy_res    (busy_res),
        .read_byte   (read_byte),
        .byte_valid  (byte_valid),
        .last_byte   (last_byte),
        .ack_missing (ack_missing),
        .done_res    (done_res)
    );

    always #HALF_PERIOD clk = ~clk;

    function automatic bus_state_t idle_bus();
        bus_state_t s;
        s.phase      = PH_IDLE;
        s.sub        = 2'd0;
        s.bit_index  = 4'd0;
        s.shift_byte = 8'd0;
        s.bytes_left = 8'd0;
        s.retry_left = 16'd0;
        s.dev_addr   = 7'd0;
        s.reg_byte   = 8'd0;
        s.data_byte  = 8'd0;
        s.ack_error  = 1'b0;
        s.read_mode  = 1'b0;
        return s;
    endfunction

    function automatic void load_byte(inout bus_state_t s, input bus_phase_t p,
                                      input logic [7:0] b);
        s.phase      = p;
        s.shift_byte = b;
        s.bit_index  = 4'd0;
        s.sub        = 2'd0;
    endfunction

    function automatic void finish_ack(inout bus_state_t s);
        s.sub = 2'd0;
        if (s.phase == PH_ACK_DEVW)
            load_byte(s, PH_REG, s.reg_byte);
        else if (s.phase == PH_ACK_REG)
        begin
            if (s.read_mode)
                s.phase = PH_RESTART;
            else
                load_byte(s, PH_DATA, s.data_byte);
        end
        else if (s.phase == PH_ACK_DEVR)
        begin
            if (s.bytes_left == 8'd0)
                s.phase = PH_STOP;
            else
                load_byte(s, PH_READ, 8'd0);
        end
        else
            s.phase = PH_STOP;
    endfunction

    function automatic res_t predict_bus_step(inout bus_state_t s, input logic [15:0] limit,
                                              input req_t r);
        res_t o;
        logic msb;
        o           = '0;
        o.scl_level = 1'b1;
        o.sda_level = 1'b1;
        msb         = s.shift_byte[7];
        case (s.phase)
            PH_START, PH_RESTART:
            begin
                if (s.sub == 2'd0)
                    s.sub = 2'd1;
                else if (s.sub == 2'd1)
                begin
                    o.sda_level = 1'b0;
                    s.sub       = 2'd2;
                end
                else
                begin
                    o.scl_level = 1'b0;
                    o.sda_level = 1'b0;
                    if (s.phase == PH_START)
                        load_byte(s, PH_DEVW, {s.dev_addr, 1'b0});
                    else
                        load_byte(s, PH_DEVR, {s.dev_addr, 1'b1});
                end
            end
            PH_DEVW, PH_REG, PH_DATA, PH_DEVR:
            begin
                o.sda_level = msb;
                if (s.sub == 2'd0)
                begin
                    o.scl_level = 1'b0;
                    s.sub       = 2'd1;
                end
                else if (s.sub == 2'd1)
                    s.sub = 2'd2;
                else
                begin
                    o.scl_level  = 1'b0;
                    s.shift_byte = {s.shift_byte[6:0], 1'b0};
                    if (s.bit_index >= 4'd7)
                    begin
                        o.sda_level  = 1'b1;
                        s.phase      = (s.phase == PH_DEVW) ? PH_ACK_DEVW :
                                       (s.phase == PH_REG)  ? PH_ACK_REG  :
                                       (s.phase == PH_DATA) ? PH_ACK_DATA : PH_ACK_DEVR;
                        s.sub        = 2'd0;
                        s.retry_left = (limit == 16'd0) ? 16'd1 : limit;
                    end
                    else
                    begin
                        s.bit_index = s.bit_index + 4'd1;
                        s.sub       = 2'd0;
                    end
                end
            end
            PH_ACK_DEVW, PH_ACK_REG, PH_ACK_DATA, PH_ACK_DEVR:
            begin
                if (s.sub == 2'd0)
                begin
                    o.scl_level = 1'b0;
                    s.sub       = 2'd1;
                end
                else if (s.sub == 2'd1)
                    s.sub = 2'd2;
                else
                begin
                    o.scl_level = 1'b0;
                    if (!r.sda_in)
                        finish_ack(s);
                    else
                    begin
                        s.retry_left = s.retry_left - 16'd1;
                        if (s.retry_left == 16'd0)
                        begin
                            s.ack_error = 1'b1;
                            finish_ack(s);
                        end
                        else
                            s.sub = 2'd0;
                    end
                end
            end
            PH_READ:
            begin
                if (s.sub == 2'd0)
                    s.sub = 2'd1;
                else
                begin
                    o.scl_level  = 1'b0;
                    s.shift_byte = {s.shift_byte[6:0], r.sda_in};
                    s.bit_index  = s.bit_index + 4'd1;
                    s.sub        = 2'd0;
                    if (s.bit_index >= 4'd8)
                    begin
                        o.byte_valid = 1'b1;
                        o.read_byte  = s.shift_byte;
                        o.last_byte  = (s.bytes_left == 8'd1);
                        s.bytes_left = s.bytes_left - 8'd1;
                        s.phase      = PH_MACK;
                    end
                end
            end
            PH_MACK:
            begin
                o.sda_level = (s.bytes_left == 8'd0);
                if (s.sub == 2'd0)
                begin
                    o.scl_level = 1'b0;
                    s.sub       = 2'd1;
                end
                else if (s.sub == 2'd1)
                    s.sub = 2'd2;
                else
                begin
                    o.scl_level = 1'b0;
                    if (s.bytes_left == 8'd0)
                    begin
                        s.phase = PH_STOP;
                        s.sub   = 2'd0;
                    end
                    else
                        load_byte(s, PH_READ, 8'd0);
                end
            end
            PH_STOP:
            begin
                if (s.sub == 2'd0)
                begin
                    o.sda_level = 1'b0;
                    s.sub       = 2'd1;
                end
                else
                begin
                    o.done_res = 1'b1;
                    s.phase    = PH_IDLE;
                    s.sub      = 2'd0;
                end
            end
            default:
            begin
                s.phase = PH_IDLE;
                s.sub   = 2'd0;
                if (r.kind == KIND_WRITE || r.kind == KIND_READ)
                begin
                    s.dev_addr   = r.device_addr;
                    s.reg_byte   = r.reg_addr;
                    s.data_byte  = r.write_data;
                    s.bytes_left = r.read_count;
                    s.read_mode  = (r.kind == KIND_READ);
                    s.ack_error  = 1'b0;
                    s.phase      = PH_START;
                    s.sub        = 2'd1;
                end
            end
        endcase
        o.busy_res    = (s.phase != PH_IDLE);
        o.ack_missing = s.ack_error;
        return o;
    endfunction

    function automatic req_t random_request();
        req_t r;
        r.kind        = KIND_TICK;
        r.sda_in      = 1'($urandom_range(0, 1));
        r.device_addr = 7'($urandom_range(0, 127));
        r.reg_addr    = 8'($urandom_range(0, 255));
        r.write_data  = 8'($urandom_range(0, 255));
        r.read_count  = 8'($urandom_range(0, 255));
        return r;
    endfunction

    task automatic queue_request(input req_t r);
        res_t ignored;
        ignored = predict_bus_step(plan_bus, plan_limit, r);
        pending_requests.push_back(r);
        planned_items++;
    endtask

    task automatic plan_idle(input int count);
        req_t r;
        for (int i = 0; i < count; i++)
        begin
            r = random_request();
            if ($urandom_range(0, 3) == 0)
                r.kind = KIND_UNUSED;
            queue_request(r);
        end
    endtask

    task automatic plan_transaction(input logic [1:0] op, input logic [6:0] dev,
                                    input logic [7:0] regb, input logic [7:0] data,
                                    input logic [7:0] count, input int ack_pct);
        req_t r;
        int   pick;
        r             = random_request();
        r.kind        = op;
        r.device_addr = dev;
        r.reg_addr    = regb;
        r.write_data  = data;
        r.read_count  = count;
        queue_request(r);
        while (plan_bus.phase != PH_IDLE)
        begin
            r    = random_request();
            pick = $urandom_range(0, 99);
            // A few requests arrive while the bus is busy and must be ignored.
            if (pick < 4)
                r.kind = KIND_UNUSED;
            else if (pick < 7)
                r.kind = KIND_WRITE;
            else if (pick < 10)
                r.kind = KIND_READ;
            if ((plan_bus.phase == PH_ACK_DEVW || plan_bus.phase == PH_ACK_REG ||
                 plan_bus.phase == PH_ACK_DATA || plan_bus.phase == PH_ACK_DEVR) &&
                plan_bus.sub == 2'd2)
                r.sda_in = ($urandom_range(0, 99) < ack_pct) ? 1'b0 : 1'b1;
            queue_request(r);
        end
    endtask

    task automatic plan_random(input int budget, input int ack_pct);
        int         start;
        logic [1:0] op;
        logic [7:0] count;
        start = planned_items;
        while (planned_items - start < budget)
        begin
            plan_idle($urandom_range(0, 3));
            op    = ($urandom_range(0, 1) == 0) ? KIND_WRITE : KIND_READ;
            count = ($urandom_range(0, 9) < 8) ? 8'($urandom_range(0, 3)) :
                                                 8'($urandom_range(0, 12));
            plan_transaction(op, 7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)),
                             8'($urandom_range(0, 255)), count, ack_pct);
        end
    endtask

    task automatic write_retry_limit(input logic [15:0] value);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we      <= 1'b0;
        cfg_data    <= 16'($urandom_range(0, 65535));
        model_limit = value;
        plan_limit  = value;
        @(negedge clk);
    endtask

    task automatic wait_drain();
        do
            @(negedge clk);
        while (pending_requests.size() != 0 || expected_levels.size() != 0 || in_valid);
        repeat (4) @(negedge clk);
    endtask

    task automatic report_mismatch(input string msg);
        error_count++;
        if (error_count <= 40)
            $display("ERROR at %0t ns: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input logic [7:0] got,
                               input logic [7:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        req_t sent_req;
        req_t next_req;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                sent_req = {kind, sda_in, device_addr, reg_addr, write_data, read_count};
                expected_levels.push_back(predict_bus_step(model_bus, model_limit, sent_req));
                accepted_requests++;
            end
            if (!in_valid || in_ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (pending_requests.size() > 0)
                begin
                    next_req = pending_requests.pop_front();
                    in_valid <= 1'b1;
                    {kind, sda_in, device_addr, reg_addr, write_data, read_count} <= next_req;
                    if (burst_left > 0)
                        burst_left--;
                    else
                    begin
                        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300) :
                                                                   $urandom_range(0, 31);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        res_t got_levels;
        res_t want_levels;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                got_levels = {scl_level, sda_level, busy_res, read_byte, byte_valid,
                              last_byte, ack_missing, done_res};
                if (expected_levels.size() == 0)
                    report_mismatch("result arrived with no request outstanding");
                else
                begin
                    want_levels = expected_levels.pop_front();
                    check_field("scl_level", 8'(got_levels.scl_level),
                                8'(want_levels.scl_level));
                    check_field("sda_level", 8'(got_levels.sda_level),
                                8'(want_levels.sda_level));
                    check_field("busy_res", 8'(got_levels.busy_res),
                                8'(want_levels.busy_res));
                    check_field("read_byte", got_levels.read_byte, want_levels.read_byte);
                    check_field("byte_valid", 8'(got_levels.byte_valid),
                                8'(want_levels.byte_valid));
                    check_field("last_byte", 8'(got_levels.last_byte),
                                8'(want_levels.last_byte));
                    check_field("ack_missing", 8'(got_levels.ack_missing),
                                8'(want_levels.ack_missing));
                    check_field("done_res", 8'(got_levels.done_res),
                                8'(want_levels.done_res));
                    steps_checked++;
                    if (want_levels.byte_valid)
                        bytes_received++;
                    if (want_levels.done_res)
                    begin
                        transactions_done++;
                        if (want_levels.ack_missing)
                            nacked_transactions++;
                    end
                end
            end
            if (long_hold_request)
            begin
                hold_left         = LONG_HOLD_CYCLES;
                long_hold_request = 1'b0;
            end
            if (stall_timer == 0)
            begin
                stall_mode  = $urandom_range(0, 2);
                stall_timer = $urandom_range(20, 120);
            end
            else
                stall_timer--;
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (stall_mode == 0)
                out_ready <= 1'b1;
            else if (stall_mode == 1)
                out_ready <= ($urandom_range(0, 3) != 0);
            else
                out_ready <= ((stall_timer % 7) < 4);
        end
    end

    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Timeout: no request or result moved for %0d cycles", WATCHDOG_LIMIT);
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        model_bus   = idle_bus();
        plan_bus    = idle_bus();
        model_limit = ACK_RETRY_RESET;
        plan_limit  = ACK_RETRY_RESET;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);
        @(negedge clk);

        plan_idle(3);
        plan_transaction(KIND_WRITE, 7'h7F, 8'hFF, 8'hFF, 8'hFF, 100);
        plan_transaction(KIND_READ, 7'h55, 8'hAA, 8'h00, 8'd0, 100);
        plan_transaction(KIND_READ, 7'h2A, 8'h81, 8'h5A, 8'd3, 70);
        plan_idle(3);
        wait_drain();

        write_retry_limit(16'd1);
        plan_transaction(KIND_WRITE, 7'h33, 8'h44, 8'h55, 8'd0, 0);
        plan_transaction(KIND_READ, 7'h66, 8'h77, 8'h88, 8'd2, 0);
        wait_drain();

        write_retry_limit(16'd0);
        plan_transaction(KIND_READ, 7'h01, 8'h02, 8'h03, 8'd1, 0);
        wait_drain();

        write_retry_limit(16'hFFFF);
        plan_transaction(KIND_WRITE, 7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)),
                         8'($urandom_range(0, 255)), 8'd0, 90);
        wait_drain();

        // The receiver holds off while requests keep coming, so the input side fills.
        write_retry_limit(16'd3);
        long_hold_request = 1'b1;
        plan_random(60, 60);
        wait_drain();

        repeat (10) @(posedge clk);
        if (expected_levels.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_levels.size()));
        $display("Checked %0d bus steps: %0d transactions completed, %0d bytes read back.",
                 steps_checked, transactions_done, bytes_received);
        $display("%0d transactions lost an acknowledge; retry limits 0, 1, 3, 1000, 65535 used.",
                 nacked_transactions);
        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

@@ i2c_register_access_master_top.f @@
+incdir+src
src/i2c_ram_pkg.sv
src/i2c_ram_in_stage.sv
src/i2c_ram_seq.sv
src/i2c_ram_out_stage.sv
src/i2c_register_access_master_top.sv
bench/tb_i2c_register_access_master_top.sv
